// File: hw/rtl/stc_pkg.sv
// stc_pkg: token classes, lexer modes and the transaction structs shared by
// the classifier front end, the result queue and the top level. No dependencies.
`default_nettype none
package stc_pkg;

  localparam logic [2:0] CL_TEXT     = 3'd0;
  localparam logic [2:0] CL_COMMENT  = 3'd1;
  localparam logic [2:0] CL_STRING   = 3'd2;
  localparam logic [2:0] CL_NUMBER   = 3'd3;
  localparam logic [2:0] CL_KEYWORD  = 3'd4;
  localparam logic [2:0] CL_IDENT    = 3'd5;
  localparam logic [2:0] CL_OPERATOR = 3'd6;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_CHARLIT = 3'd3;
  localparam logic [2:0] M_NUMBER  = 3'd4;
  localparam logic [2:0] M_WORD    = 3'd5;
  localparam logic [2:0] M_IDENT   = 3'd6;

  localparam int NUM_KW = 28;
  localparam int KW_LEN = 8;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  token_class;
    logic [15:0] run_length;
    logic        last_of_run;
  } result_t;

  // Up to three results caused by one byte.
  typedef struct packed {
    logic [1:0]  count;
    result_t [2:0] res;
  } group_t;

  // Keyword text, padded with zero bytes; character 0 in bits [7:0].
  function automatic logic [63:0] kw_word(input int k);
    logic [63:0] w;
    w = 64'd0;
    case (k)
      0:  w = {40'd0, "tel"};
      1:  w = {48'd0, "eb"};
      2:  w = {40'd0, "dna"};
      3:  w = {48'd0, "ro"};
      4:  w = {40'd0, "ton"};
      5:  w = {48'd0, "fi"};
      6:  w = {32'd0, "neht"};
      7:  w = {32'd0, "esle"};
      8:  w = {40'd0, "rof"};
      9:  w = {48'd0, "ot"};
      10: w = {48'd0, "yb"};
      11: w = {24'd0, "elihw"};
      12: w = {48'd0, "od"};
      13: w = {24'd0, "litnu"};
      14: w = {16'd0, "taeper"};
      15: w = {24'd0, "kaerb"};
      16: w = {16'd0, "nruter"};
      17: w = "nohctiws";
      18: w = {32'd0, "esac"};
      19: w = {8'd0, "tluafed"};
      20: w = "tsefinam";
      21: w = {16'd0, "labolg"};
      22: w = {16'd0, "citats"};
      23: w = {16'd0, "nretxe"};
      24: w = {32'd0, "eurt"};
      25: w = {24'd0, "eslaf"};
      26: w = {40'd0, "lin"};
      27: w = {32'd0, "diov"};
      default: w = 64'd0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    n = 4'd0;
    case (k)
      1, 3, 5, 9, 10, 12: n = 4'd2;
      0, 2, 4, 8, 26: n = 4'd3;
      6, 7, 18, 24, 27: n = 4'd4;
      11, 13, 15, 25: n = 4'd5;
      14, 16, 21, 22, 23: n = 4'd6;
      19: n = 4'd7;
      17, 20: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_xdigit(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    logic r;
    r = 1'b0;
    case (b)
      "+", "-", "*", "/", "%", "(", ")", "[", "]", "{", "}", ".", ",", ";",
      ":", "=", "<", ">", "!", "&", "|", "~", "^", "?": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stc_front.sv
// stc_front: lexer state machine and run-length builder; turns one byte per
// cycle, when stepped, into a group of up to three results. Uses stc_pkg.
`default_nettype none
module stc_front #(
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int MAX_RUN = 65535
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_text,
  output stc_pkg::group_t      grp
);
  import stc_pkg::*;

  localparam int WLW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int WIW = $clog2(MAX_KEYWORD_LEN);

  logic [2:0]  lex_mode, lex_mode_next;
  logic [16:0] run_count, run_count_next;
  logic [2:0]  run_class, run_class_next;
  logic [WLW-1:0] word_length, word_length_next;
  logic [7:0]  word_chars [MAX_KEYWORD_LEN];
  logic        slash_held, slash_held_next;
  logic        hash_held, hash_held_next;
  logic        escape_pending, escape_pending_next;
  logic [1:0]  char_literal_step, char_literal_step_next;
  logic        wr_en;
  logic [WIW-1:0] wr_idx;

  // Keyword match on the held word, all comparators in parallel.
  logic kw_hit;
  always_comb begin
    logic [63:0] w;
    logic m;
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      w = kw_word(k);
      m = (word_length == WLW'(kw_len(k)));
      for (int j = 0; j < KW_LEN; j++) begin
        if (j < MAX_KEYWORD_LEN && j < int'(kw_len(k)))
          if (word_chars[j] != w[j*8 +: 8]) m = 1'b0;
      end
      if (m) kw_hit = 1'b1;
    end
  end

  // Keyword test at end of text on the held word extended by this byte.
  logic wcls_eot;
  always_comb begin
    logic [63:0] w;
    logic m;
    logic [7:0] c;
    wcls_eot = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      w = kw_word(k);
      m = (word_length + 1'b1 == WLW'(kw_len(k)));
      for (int j = 0; j < KW_LEN; j++) begin
        if (j < MAX_KEYWORD_LEN && j < int'(kw_len(k))) begin
          c = (word_length == WLW'(j)) ? text_byte : word_chars[j];
          if (c != w[j*8 +: 8]) m = 1'b0;
        end
      end
      if (m) wcls_eot = 1'b1;
    end
  end

  always_comb begin
    logic [1:0] n;
    result_t [2:0] r;
    logic [16:0] rc;
    logic [2:0] rcl;
    logic fr;
    logic [7:0] b;
    logic [2:0] a_cls;
    logic [16:0] a_len;
    logic [2:0] wcls;

    b = text_byte;
    n = 2'd0;
    r = '0;
    rc = run_count;
    rcl = run_class;
    lex_mode_next = lex_mode;
    word_length_next = word_length;
    slash_held_next = slash_held;
    hash_held_next = hash_held;
    escape_pending_next = escape_pending;
    char_literal_step_next = char_literal_step;
    wr_en = 1'b0;
    wr_idx = '0;
    fr = 1'b0;
    a_cls = CL_TEXT;
    a_len = 17'd0;
    wcls = kw_hit ? CL_KEYWORD : CL_IDENT;

    // First append: held prefix, word resolve, or the mode action.
    if (slash_held) begin
      slash_held_next = 1'b0;
      if (b == "/") begin
        a_cls = CL_COMMENT; a_len = 17'd2; lex_mode_next = M_COMMENT;
      end else begin
        a_cls = (b == "*") ? CL_COMMENT : CL_OPERATOR; a_len = 17'd1; fr = 1'b1;
      end
    end else if (hash_held) begin
      hash_held_next = 1'b0;
      if (is_xdigit(b)) begin
        a_cls = CL_NUMBER; a_len = 17'd2; lex_mode_next = M_NUMBER;
      end else begin
        a_cls = CL_TEXT; a_len = 17'd1; fr = 1'b1;
      end
    end else begin
      case (lex_mode)
        M_COMMENT: begin a_cls = CL_COMMENT; a_len = 17'd1; end
        M_STRING: begin
          a_cls = CL_STRING; a_len = 17'd1;
          if (escape_pending) escape_pending_next = 1'b0;
          else if (b == "\\") escape_pending_next = 1'b1;
          else if (b == "\"") lex_mode_next = M_IDLE;
        end
        M_CHARLIT: begin
          if (char_literal_step == 2'd1) begin
            a_cls = CL_STRING; a_len = 17'd1; char_literal_step_next = 2'd2;
          end else begin
            char_literal_step_next = 2'd0;
            if (b == "'") begin
              a_cls = CL_STRING; a_len = 17'd1; lex_mode_next = M_IDLE;
            end else fr = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_xdigit(b) || b == "x" || b == "X") begin
            a_cls = CL_NUMBER; a_len = 17'd1;
          end else fr = 1'b1;
        end
        M_WORD: begin
          if (is_word(b)) begin
            if (word_length < WLW'(MAX_KEYWORD_LEN)) begin
              wr_en = 1'b1; wr_idx = word_length[WIW-1:0];
              word_length_next = word_length + 1'b1;
            end else begin
              a_cls = CL_IDENT; a_len = 17'(MAX_KEYWORD_LEN + 1);
              word_length_next = '0; lex_mode_next = M_IDENT;
            end
          end else begin
            a_cls = wcls; a_len = 17'(word_length);
            word_length_next = '0; fr = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(b)) begin a_cls = CL_IDENT; a_len = 17'd1; end
          else fr = 1'b1;
        end
        default: fr = 1'b1;
      endcase
    end

    // append #1
    if (a_len != 17'd0 || (lex_mode == M_WORD && !slash_held && !hash_held && fr)) begin
      if (rc != 17'd0 && rcl != a_cls) begin
        r[n] = '{rcl, rc[15:0], 1'b0}; n = n + 1'b1; rc = '0;
      end
      rcl = a_cls; rc = rc + a_len;
      if (rc >= 17'(MAX_RUN)) begin
        r[n] = '{a_cls, 16'(MAX_RUN), 1'b0}; n = n + 1'b1; rc = rc - 17'(MAX_RUN);
      end
    end

    // fresh(b): at most one more append
    a_len = 17'd0;
    if (fr) begin
      lex_mode_next = M_IDLE;
      if (is_space(b)) begin a_cls = CL_TEXT; a_len = 17'd1; end
      else if (b == "/") slash_held_next = 1'b1;
      else if (b == "\"") begin
        a_cls = CL_STRING; a_len = 17'd1; lex_mode_next = M_STRING;
        escape_pending_next = 1'b0;
      end else if (b == "'") begin
        a_cls = CL_STRING; a_len = 17'd1; lex_mode_next = M_CHARLIT;
        char_literal_step_next = 2'd1;
      end else if (is_digit(b)) begin
        a_cls = CL_NUMBER; a_len = 17'd1; lex_mode_next = M_NUMBER;
      end else if (b == "#") hash_held_next = 1'b1;
      else if (is_alpha(b) || b == "_") begin
        wr_en = 1'b1; wr_idx = '0; word_length_next = WLW'(1); lex_mode_next = M_WORD;
      end else if (is_op(b)) begin a_cls = CL_OPERATOR; a_len = 17'd1; end
      else begin a_cls = CL_TEXT; a_len = 17'd1; end
    end

    // End of text: a held slash or hash; a pending word is one char long
    // only when just started, and always an identifier or keyword.
    if (end_of_text) begin
      if (slash_held_next) begin a_cls = CL_OPERATOR; a_len = 17'd1; end
      if (hash_held_next) begin a_cls = CL_TEXT; a_len = 17'd1; end
    end
    if (a_len != 17'd0) begin
      if (rc != 17'd0 && rcl != a_cls) begin
        r[n] = '{rcl, rc[15:0], 1'b0}; n = n + 1'b1; rc = '0;
      end
      rcl = a_cls; rc = rc + a_len;
      if (rc >= 17'(MAX_RUN)) begin
        r[n] = '{a_cls, 16'(MAX_RUN), 1'b0}; n = n + 1'b1; rc = rc - 17'(MAX_RUN);
      end
    end

    if (end_of_text) begin
      // Pending word: either continued this byte or freshly started.
      if (lex_mode_next == M_WORD) begin
        if (fr) wcls = CL_IDENT;
        else wcls = wcls_eot ? CL_KEYWORD : CL_IDENT;
        a_len = 17'(word_length_next);
        if (rc != 17'd0 && rcl != wcls) begin
          r[n] = '{rcl, rc[15:0], 1'b0}; n = n + 1'b1; rc = '0;
        end
        rcl = wcls; rc = rc + a_len;
        if (rc >= 17'(MAX_RUN)) begin
          r[n] = '{wcls, 16'(MAX_RUN), 1'b0}; n = n + 1'b1; rc = rc - 17'(MAX_RUN);
        end
      end
      if (rc != 17'd0) begin
        r[n] = '{rcl, rc[15:0], 1'b0}; n = n + 1'b1;
      end
      rc = '0; rcl = CL_TEXT;
      lex_mode_next = M_IDLE; word_length_next = '0;
      slash_held_next = 1'b0; hash_held_next = 1'b0;
      escape_pending_next = 1'b0; char_literal_step_next = 2'd0;
    end

    if (n != 2'd0) r[n - 1'b1].last_of_run = 1'b1;
    grp.count = n;
    grp.res = r;
    run_count_next = rc;
    run_class_next = rcl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE;
      run_count <= '0;
      run_class <= CL_TEXT;
      word_length <= '0;
      slash_held <= 1'b0;
      hash_held <= 1'b0;
      escape_pending <= 1'b0;
      char_literal_step <= 2'd0;
    end else if (step) begin
      lex_mode <= lex_mode_next;
      run_count <= run_count_next;
      run_class <= run_class_next;
      word_length <= word_length_next;
      slash_held <= slash_held_next;
      hash_held <= hash_held_next;
      escape_pending <= escape_pending_next;
      char_literal_step <= char_literal_step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) word_chars[wr_idx] <= text_byte;
  end
endmodule
`default_nettype wire

// File: hw/rtl/stc_queue.sv
// stc_queue: four-entry queue of result groups between the front end and
// the output serializer. Uses stc_pkg.
`default_nettype none
module stc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  stc_pkg::group_t      push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output stc_pkg::group_t      head
);
  import stc_pkg::*;

  group_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full = cnt == 3'd4;
  assign empty = cnt == 3'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end
endmodule
`default_nettype wire

// File: hw/rtl/source_token_classifier.sv
// source_token_classifier: top level using stc_pkg; lexer front end, result
// queue submodules and output stage: one result per cycle unless stalled.
//
// Usage: text bytes enter on in_valid/in_stall with text_byte and
// end_of_text; a byte is taken at an edge with in_valid high and in_stall
// low. Results leave on out_valid/out_stall as token_class, run_length and
// last_of_run, last_of_run marking the final result of one input byte.
// Throughput: one byte per cycle while in_stall is low; a byte's results
// leave the output one at a time, so bursts of multi-result bytes stall
// the input once the four-group queue fills. The group is queued at the
// edge that takes the byte, and its results are loaded from the queue
// head into the output register. Keyword compare runs on all 28 words
// in parallel inside the front end.
// Reset clears the lexer, queue and output stage; no cleanup pass.
// When the receiver stalls, the output holds and the queue fills, then
// in_stall rises; bytes making no result need no queue slot, so they
// keep flowing until the queue is full.
`default_nettype none
module source_token_classifier #(
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int MAX_RUN = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_class,
  output logic [15:0]      run_length,
  output logic             last_of_run
);
  import stc_pkg::*;

  group_t grp, head;
  logic full, empty, step, pop;
  logic [1:0] idx;

  assign in_stall = full;
  assign step = in_valid && !full;

  stc_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .MAX_RUN(MAX_RUN)) u_front (
    .clk(clk), .rst(rst), .step(step), .text_byte(text_byte),
    .end_of_text(end_of_text), .grp(grp)
  );

  stc_queue u_queue (
    .clk(clk), .rst(rst), .push(step && grp.count != 2'd0), .push_data(grp),
    .full(full), .pop(pop), .empty(empty), .head(head)
  );

  // Output register: walks the head group one result per transaction.
  logic load;
  assign load = !empty && (!out_valid || !out_stall);
  assign pop = load && (idx + 1'b1 == head.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; idx <= '0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !empty;
      if (load) idx <= pop ? 2'd0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_class <= head.res[idx].token_class;
      run_length <= head.res[idx].run_length;
      last_of_run <= head.res[idx].last_of_run;
    end
  end
endmodule
`default_nettype wire
